>>> rtl/core/vtc_pkg.sv
// Shared types and constants of the voice turn controller.
`default_nettype none

package vtc_pkg;

   localparam int unsigned NowWidth    = 64;
   localparam int unsigned LimitWidth  = 32;
   localparam int unsigned CountWidth  = 32;
   localparam int unsigned ActionWidth = 4;
   localparam int unsigned CsrIdxWidth = 8;
   localparam int unsigned RspWidth    = 80;

   localparam logic [LimitWidth-1:0] ListenLimitReset   = 32'd8000;
   localparam logic [LimitWidth-1:0] ResponseLimitReset = 32'd15000;
   localparam logic [CountWidth-1:0] CountMax           = 32'hFFFF_FFFF;

   localparam logic [CsrIdxWidth-1:0] CSR_LISTEN_LIMIT   = 8'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_RESPONSE_LIMIT = 8'd1;

   typedef enum logic [2:0] {
      PH_READY   = 3'd0,
      PH_START   = 3'd1,
      PH_LISTEN  = 3'd2,
      PH_WAIT    = 3'd3,
      PH_SPEAK   = 3'd4,
      PH_RESUME  = 3'd5,
      PH_STOPPED = 3'd6,
      PH_FAILED  = 3'd7
   } phase_type;

   typedef enum logic [2:0] {
      RS_NONE    = 3'd0,
      RS_REVOKED = 3'd1,
      RS_NETWORK = 3'd2,
      RS_SESSION = 3'd3,
      RS_USER    = 3'd4,
      RS_TIMEOUT = 3'd5,
      RS_QUIET   = 3'd6
   } reason_type;

   typedef enum logic [3:0] {
      EV_REVOKE     = 4'd0,
      EV_DISCONNECT = 4'd1,
      EV_BADSESS    = 4'd2,
      EV_BUTTON     = 4'd3,
      EV_LISTEN     = 4'd4,
      EV_TXFRAME    = 4'd5,
      EV_STT        = 4'd6,
      EV_TTSSTART   = 4'd7,
      EV_RXAUDIO    = 4'd8,
      EV_TTSSTOP    = 4'd9,
      EV_DRAINED    = 4'd10,
      EV_TICK       = 4'd11,
      EV_NONE       = 4'd12
   } event_type;

   typedef struct packed {
      event_type            ev;
      logic [NowWidth-1:0]  now;
   } cmd_type;

   typedef struct packed {
      logic                     valid;
      logic [CsrIdxWidth-1:0]   index;
      logic [LimitWidth-1:0]    data;
   } csr_wr_type;

endpackage

`default_nettype wire

>>> rtl/core/vtc_front.sv
// Input stage: takes request beats and classifies the action code.
`default_nettype none

module vtc_front (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [vtc_pkg::NowWidth-1:0]      req_tdata,
   input  wire logic [vtc_pkg::ActionWidth-1:0]   req_tuser,
   output logic                                   cmd_valid,
   input  wire logic                              cmd_ready,
   output vtc_pkg::cmd_type                       cmd
);

   logic             valid_ff, valid_in;
   vtc_pkg::cmd_type cmd_ff, cmd_in;

   assign req_tready = !valid_ff || cmd_ready;
   assign cmd_valid  = valid_ff;
   assign cmd        = cmd_ff;

   always_comb begin
      valid_in   = valid_ff;
      cmd_in     = cmd_ff;
      cmd_in.now = req_tdata;
      if (req_tuser <= vtc_pkg::EV_TICK) begin
         cmd_in.ev = vtc_pkg::event_type'(req_tuser);
      end else begin
         cmd_in.ev = vtc_pkg::EV_NONE;
      end
      if (req_tready) begin
         valid_in = req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/vtc_queue.sv
// Two-entry queue of classified events between the front and the back.
`default_nettype none

module vtc_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire vtc_pkg::cmd_type push_cmd,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output vtc_pkg::cmd_type      pop_cmd
);

   vtc_pkg::cmd_type entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/vtc_back.sv
// Session state update, timeout checks, limit registers and result register.
`default_nettype none

module vtc_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              cmd_valid,
   output logic                                   cmd_ready,
   input  wire vtc_pkg::cmd_type                  cmd,
   input  wire vtc_pkg::csr_wr_type               csr_wr,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [vtc_pkg::RspWidth-1:0]           rsp_tdata
);

   logic [vtc_pkg::LimitWidth-1:0] listen_limit_ff, response_limit_ff;
   vtc_pkg::phase_type             phase_ff, phase_in;
   vtc_pkg::reason_type            reason_ff, reason_in;
   logic [vtc_pkg::CountWidth-1:0] frames_ff, frames_in;
   logic [vtc_pkg::CountWidth-1:0] turns_ff, turns_in;
   logic                           heard_ff, heard_in;
   logic [vtc_pkg::NowWidth-1:0]   listen_start_ff, listen_start_in;
   logic [vtc_pkg::NowWidth-1:0]   progress_ff, progress_in;
   logic                           rsp_valid_ff;
   logic [vtc_pkg::RspWidth-1:0]   rsp_data_ff, rsp_data_in;

   logic [vtc_pkg::NowWidth-1:0]   listen_elapsed, progress_elapsed;
   logic                           listen_due, response_due;
   logic                           playing, terminal, take;

   assign cmd_ready  = !rsp_valid_ff || rsp_tready;
   assign take       = cmd_valid && cmd_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign listen_elapsed   = cmd.now - listen_start_ff;
   assign progress_elapsed = cmd.now - progress_ff;
   assign listen_due   = listen_elapsed >= {32'd0, listen_limit_ff};
   assign response_due = progress_elapsed >= {32'd0, response_limit_ff};
   assign playing  = (phase_ff == vtc_pkg::PH_WAIT) || (phase_ff == vtc_pkg::PH_SPEAK);
   assign terminal = (phase_ff == vtc_pkg::PH_STOPPED) || (phase_ff == vtc_pkg::PH_FAILED);

   always_comb begin
      phase_in        = phase_ff;
      reason_in       = reason_ff;
      frames_in       = frames_ff;
      turns_in        = turns_ff;
      heard_in        = heard_ff;
      listen_start_in = listen_start_ff;
      progress_in     = progress_ff;
      if (!terminal) begin
         unique case (cmd.ev)
            vtc_pkg::EV_REVOKE: begin
               phase_in  = vtc_pkg::PH_STOPPED;
               reason_in = vtc_pkg::RS_REVOKED;
               frames_in = '0;
            end
            vtc_pkg::EV_DISCONNECT: begin
               phase_in  = vtc_pkg::PH_FAILED;
               reason_in = vtc_pkg::RS_NETWORK;
               frames_in = '0;
            end
            vtc_pkg::EV_BADSESS: begin
               phase_in  = vtc_pkg::PH_FAILED;
               reason_in = vtc_pkg::RS_SESSION;
               frames_in = '0;
            end
            vtc_pkg::EV_BUTTON: begin
               if (phase_ff == vtc_pkg::PH_READY) begin
                  phase_in = vtc_pkg::PH_START;
               end else begin
                  phase_in  = vtc_pkg::PH_STOPPED;
                  reason_in = vtc_pkg::RS_USER;
                  frames_in = '0;
               end
            end
            vtc_pkg::EV_LISTEN: begin
               if (phase_ff == vtc_pkg::PH_START) begin
                  phase_in        = vtc_pkg::PH_LISTEN;
                  listen_start_in = cmd.now;
                  progress_in     = cmd.now;
                  frames_in       = '0;
                  heard_in        = 1'b0;
                  turns_in        = turns_ff + 32'd1;
               end
            end
            vtc_pkg::EV_TXFRAME: begin
               if (phase_ff == vtc_pkg::PH_LISTEN && frames_ff != vtc_pkg::CountMax) begin
                  frames_in = frames_ff + 32'd1;
               end
            end
            vtc_pkg::EV_STT: begin
               if (phase_ff == vtc_pkg::PH_LISTEN) begin
                  heard_in = 1'b1;
               end
            end
            vtc_pkg::EV_TTSSTART: begin
               if (phase_ff == vtc_pkg::PH_LISTEN && frames_ff != '0) begin
                  phase_in    = vtc_pkg::PH_WAIT;
                  progress_in = cmd.now;
               end
            end
            vtc_pkg::EV_RXAUDIO: begin
               if (playing) begin
                  phase_in    = vtc_pkg::PH_SPEAK;
                  progress_in = cmd.now;
               end
            end
            vtc_pkg::EV_TTSSTOP: begin
               if (playing) begin
                  phase_in = vtc_pkg::PH_RESUME;
               end
            end
            vtc_pkg::EV_DRAINED: begin
               if (phase_ff == vtc_pkg::PH_RESUME) begin
                  phase_in = vtc_pkg::PH_START;
               end
            end
            vtc_pkg::EV_TICK: begin
               if (phase_ff == vtc_pkg::PH_LISTEN && listen_due) begin
                  frames_in = '0;
                  if (heard_ff) begin
                     phase_in  = vtc_pkg::PH_FAILED;
                     reason_in = vtc_pkg::RS_TIMEOUT;
                  end else begin
                     phase_in  = vtc_pkg::PH_STOPPED;
                     reason_in = vtc_pkg::RS_QUIET;
                  end
               end else if (playing && response_due) begin
                  phase_in  = vtc_pkg::PH_FAILED;
                  reason_in = vtc_pkg::RS_TIMEOUT;
                  frames_in = '0;
               end
            end
            default: begin
            end
         endcase
      end
      rsp_data_in = {7'd0, turns_in, frames_in,
                     (phase_in >= vtc_pkg::PH_START) && (phase_in <= vtc_pkg::PH_RESUME),
                     (phase_in == vtc_pkg::PH_WAIT) || (phase_in == vtc_pkg::PH_SPEAK),
                     (phase_in == vtc_pkg::PH_LISTEN),
                     reason_in, phase_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         listen_limit_ff   <= vtc_pkg::ListenLimitReset;
         response_limit_ff <= vtc_pkg::ResponseLimitReset;
         phase_ff          <= vtc_pkg::PH_READY;
         reason_ff         <= vtc_pkg::RS_NONE;
         frames_ff         <= '0;
         turns_ff          <= '0;
         heard_ff          <= 1'b0;
         listen_start_ff   <= '0;
         progress_ff       <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_wr.valid && csr_wr.index == vtc_pkg::CSR_LISTEN_LIMIT) begin
            listen_limit_ff <= csr_wr.data;
         end
         if (csr_wr.valid && csr_wr.index == vtc_pkg::CSR_RESPONSE_LIMIT) begin
            response_limit_ff <= csr_wr.data;
         end
         if (take) begin
            phase_ff        <= phase_in;
            reason_ff       <= reason_in;
            frames_ff       <= frames_in;
            turns_ff        <= turns_in;
            heard_ff        <= heard_in;
            listen_start_ff <= listen_start_in;
            progress_ff     <= progress_in;
            rsp_valid_ff    <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/voice_turn_controller_unit.sv
// Top level of the voice turn controller: front stage, event queue and back end.
`default_nettype none

// Takes one event beat per cycle while the status output is not stalled and returns exactly
// one status beat per event, in order. An event passes the input register, a two-entry queue
// and the state update in the back end, which registers the status beat; back-pressure on
// rsp_tready stalls that chain. The sustained rate of one event per cycle rests on the update
// of the session state and its two 64-bit timeout compares being combinational.
// Limit registers are written through the csr port, which is always ready.
module voice_turn_controller_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // [63:0] now
   input  wire logic [vtc_pkg::NowWidth-1:0]      req_tdata,
   // [3:0] action
   input  wire logic [vtc_pkg::ActionWidth-1:0]   req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [2:0] phase, [5:3] stop_reason, [6] captures, [7] plays, [8] active,
   // [40:9] frames_sent, [72:41] turn_count, [79:73] zero
   output logic [vtc_pkg::RspWidth-1:0]           rsp_tdata,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [vtc_pkg::CsrIdxWidth-1:0]   csr_index,
   input  wire logic [vtc_pkg::LimitWidth-1:0]    csr_data
);

   logic                front_valid, front_ready;
   vtc_pkg::cmd_type    front_cmd;
   logic                queue_valid, queue_ready;
   vtc_pkg::cmd_type    queue_cmd;
   vtc_pkg::csr_wr_type csr_wr;

   assign csr_ready    = 1'b1;
   assign csr_wr.valid = csr_valid && csr_ready;
   assign csr_wr.index = csr_index;
   assign csr_wr.data  = csr_data;

   vtc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (front_valid),
      .cmd_ready  (front_ready),
      .cmd        (front_cmd)
   );

   vtc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_cmd   (front_cmd),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_cmd    (queue_cmd)
   );

   vtc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (queue_valid),
      .cmd_ready  (queue_ready),
      .cmd        (queue_cmd),
      .csr_wr     (csr_wr),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

>>> rtl/core/vtc_checker.sv
// Port-level checks of the voice turn controller and their binding to the top level.
`default_nettype none

module vtc_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic [vtc_pkg::RspWidth-1:0]      rsp_tdata
);

   logic [2:0] phase;
   logic [2:0] reason;

   assign phase  = rsp_tdata[2:0];
   assign reason = rsp_tdata[5:3];

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("status beat changed while stalled");

   a_terminal_sticks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (phase == vtc_pkg::PH_STOPPED || phase == vtc_pkg::PH_FAILED)
      |=> !rsp_tvalid || phase == vtc_pkg::PH_STOPPED || phase == vtc_pkg::PH_FAILED)
      else $error("session left a terminal phase");

   a_reason_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((reason == vtc_pkg::RS_NONE) ==
                      (phase != vtc_pkg::PH_STOPPED && phase != vtc_pkg::PH_FAILED)))
      else $error("stop reason does not match phase");

   a_ready_is_fresh: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && phase == vtc_pkg::PH_READY |-> rsp_tdata[72:9] == '0)
      else $error("counters nonzero in ready phase");

endmodule

bind voice_turn_controller_unit vtc_checker u_vtc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
